[rtl/dmc_pkg.sv]
`timescale 1ns / 1ps

package dmc_pkg;

    localparam int CFG_DATA_W  = 18;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [2:0] {
        DOOR_CLOSED  = 3'd0,
        DOOR_OPEN    = 3'd1,
        DOOR_BETWEEN = 3'd2,
        DOOR_OPENING = 3'd3,
        DOOR_CLOSING = 3'd4
    } door_t;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_RUN_LONG    = 2'd1,
        ERR_OVERCURRENT = 2'd2,
        ERR_VOLTAGE     = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        CFG_SWITCH_DEBOUNCE  = 3'd0,
        CFG_BUTTON_HOLD      = 3'd1,
        CFG_CURRENT_LIMIT    = 3'd2,
        CFG_VOLTAGE_HIGH     = 3'd3,
        CFG_VOLTAGE_LOW      = 3'd4,
        CFG_OVERCURRENT_RUNS = 3'd5,
        CFG_RUN_STEP_LIMIT   = 3'd6,
        CFG_MANUAL_TIMEOUT   = 3'd7
    } cfg_idx_t;

    localparam logic [1:0]  LIGHT_DAY             = 2'd1;
    localparam logic [1:0]  LIGHT_NIGHT           = 2'd2;
    localparam logic [1:0]  SAMPLE_LAST           = 2'd2;
    localparam logic [4:0]  DRIVE_LAST            = 5'd15;
    localparam logic [2:0]  SENSE_LAST            = 3'd5;
    localparam logic [6:0]  LIGHT_LAST            = 7'd100;
    localparam logic [7:0]  PRESS_KEEP            = 8'd49;
    localparam logic [13:0] MIN_STEPS_FOR_CURRENT = 14'd40;
    localparam logic [6:0]  BAD_VOLTAGE_RUNS      = 7'd100;

    typedef struct packed {
        logic [7:0]  switch_debounce;
        logic [7:0]  button_hold;
        logic [15:0] current_limit;
        logic [14:0] voltage_high;
        logic [14:0] voltage_low;
        logic [7:0]  overcurrent_runs;
        logic [13:0] run_step_limit;
        logic [17:0] manual_timeout;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        switch_debounce:  8'd30,
        button_hold:      8'd50,
        current_limit:    16'd2700,
        voltage_high:     15'd13500,
        voltage_low:      15'd8000,
        overcurrent_runs: 8'd10,
        run_step_limit:   14'd11000,
        manual_timeout:   18'd150000
    };

    typedef struct packed {
        logic        closed_switch;
        logic        open_switch;
        logic        push_button;
        logic [1:0]  light_class;
        logic [14:0] bus_millivolts;
        logic [15:0] motor_milliamps;
    } item_t;

    typedef struct packed {
        logic        motor_issued;
        door_t       motor_command;
        door_t       door_state;
        logic        manual_mode;
        err_t        error_event;
    } result_t;

    typedef struct packed {
        door_t       door_position;
        door_t       prior_motion;
        logic        mode_manual;
        logic [1:0]  light_state;
        logic [7:0]  closed_count;
        logic [7:0]  open_count;
        logic [7:0]  press_count;
        logic [1:0]  sample_phase;
        logic [4:0]  drive_phase;
        logic [2:0]  sense_phase;
        logic [6:0]  light_phase;
        logic [17:0] manual_elapsed;
        logic [13:0] run_steps;
        logic [7:0]  overcurrent_count;
        logic [6:0]  bad_voltage_count;
    } state_t;

    localparam state_t STATE_RESET = '{
        door_position:     DOOR_BETWEEN,
        prior_motion:      DOOR_BETWEEN,
        mode_manual:       1'b0,
        light_state:       2'd0,
        closed_count:      8'd0,
        open_count:        8'd0,
        press_count:       8'd0,
        sample_phase:      2'd0,
        drive_phase:       5'd0,
        sense_phase:       3'd0,
        light_phase:       7'd0,
        manual_elapsed:    18'd0,
        run_steps:         14'd0,
        overcurrent_count: 8'd0,
        bad_voltage_count: 7'd0
    };

    function automatic logic is_moving(door_t pos);
        return (pos == DOOR_OPENING) || (pos == DOOR_CLOSING);
    endfunction

endpackage

[rtl/door_motor_controller.sv]
`timescale 1ns / 1ps

// Door motor controller. Each input item is one millisecond tick and yields exactly
// one result item. An item is taken into an input register, its whole state update
// is done combinationally by the step logic, and the result lands in an output register,
// so the block accepts one item per clock cycle when the output side is not stalled, and
// a result is offered on the output from the output register once its item advances. The
// feedback of the controller state through the step logic sets that rate.
// Configuration writes take effect at the next clock edge.
module door_motor_controller (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_we,
    input  logic [2:0]                       cfg_addr,
    input  logic [dmc_pkg::CFG_DATA_W-1:0]   cfg_wdata,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    // closed_switch, open_switch, push_button, light_class[1:0],
    // bus_millivolts[14:0], motor_milliamps[15:0], zero fill
    input  logic [dmc_pkg::IN_TDATA_W-1:0]   s_tdata,

    output logic                             m_tvalid,
    input  logic                             m_tready,
    // motor_issued, motor_command[2:0], door_state[2:0], manual_mode,
    // error_event[1:0], zero fill
    output logic [dmc_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import dmc_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg;
    logic    in_valid_reg;
    state_t  state_reg;
    state_t  state_next;
    result_t res_next;
    result_t out_reg;
    logic    out_valid_reg;
    logic    advance;

    dmc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    dmc_step u_step (
        .st      (state_reg),
        .cfg     (cfg),
        .item    (in_item_reg),
        .st_next (state_next),
        .res     (res_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_item_reg.closed_switch   <= s_tdata[0];
            in_item_reg.open_switch     <= s_tdata[1];
            in_item_reg.push_button     <= s_tdata[2];
            in_item_reg.light_class     <= s_tdata[4:3];
            in_item_reg.bus_millivolts  <= s_tdata[19:5];
            in_item_reg.motor_milliamps <= s_tdata[35:20];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= STATE_RESET;
        end else if (advance) begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= res_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0, out_reg.error_event, out_reg.manual_mode, out_reg.door_state,
                       out_reg.motor_command, out_reg.motor_issued};

`ifndef NO_ASSERTIONS
    a_idle_cmd_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !out_reg.motor_issued |-> out_reg.motor_command == DOOR_CLOSED)
        else $error("result without command carries a nonzero command");

    a_error_has_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.error_event != ERR_NONE |-> out_reg.motor_issued)
        else $error("error reported without a motor command");

    a_voltage_stops: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_reg.error_event == ERR_VOLTAGE
        |-> out_reg.door_state == DOOR_BETWEEN && out_reg.motor_command == DOOR_BETWEEN)
        else $error("bad voltage did not stop the door between ends");

    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_valid_reg && !m_tready |-> !s_tready)
        else $error("input taken while the held item cannot advance");

    a_state_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !advance |=> state_reg == $past(state_reg))
        else $error("controller state changed without an item");
`endif

endmodule

[rtl/dmc_cfg.sv]
`timescale 1ns / 1ps

module dmc_cfg (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [2:0]                      cfg_addr,
    input  logic [dmc_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output dmc_pkg::cfg_t                   cfg
);
    import dmc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= CFG_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx_t'(cfg_addr))
                CFG_SWITCH_DEBOUNCE:  cfg_reg.switch_debounce  <= cfg_wdata[7:0];
                CFG_BUTTON_HOLD:      cfg_reg.button_hold      <= cfg_wdata[7:0];
                CFG_CURRENT_LIMIT:    cfg_reg.current_limit    <= cfg_wdata[15:0];
                CFG_VOLTAGE_HIGH:     cfg_reg.voltage_high     <= cfg_wdata[14:0];
                CFG_VOLTAGE_LOW:      cfg_reg.voltage_low      <= cfg_wdata[14:0];
                CFG_OVERCURRENT_RUNS: cfg_reg.overcurrent_runs <= cfg_wdata[7:0];
                CFG_RUN_STEP_LIMIT:   cfg_reg.run_step_limit   <= cfg_wdata[13:0];
                CFG_MANUAL_TIMEOUT:   cfg_reg.manual_timeout   <= cfg_wdata[17:0];
                default:              cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/dmc_step.sv]
`timescale 1ns / 1ps

module dmc_step (
    input  dmc_pkg::state_t  st,
    input  dmc_pkg::cfg_t    cfg,
    input  dmc_pkg::item_t   item,
    output dmc_pkg::state_t  st_next,
    output dmc_pkg::result_t res
);
    import dmc_pkg::*;

    state_t w;
    logic   press;
    logic   fired;
    logic   issued;
    door_t  cmd;
    err_t   err;

    always_comb begin
        w      = st;
        press  = 1'b0;
        fired  = 1'b0;
        issued = 1'b0;
        cmd    = DOOR_CLOSED;
        err    = ERR_NONE;

        w.manual_elapsed = (w.manual_elapsed == '1) ? w.manual_elapsed
                                                    : w.manual_elapsed + 1'b1;

        // input sampling
        if (w.sample_phase == SAMPLE_LAST) begin
            w.sample_phase = '0;
            if (item.closed_switch &&
                (w.door_position == DOOR_CLOSING || w.door_position == DOOR_BETWEEN)) begin
                w.closed_count = (w.closed_count == '1) ? w.closed_count
                                                        : w.closed_count + 1'b1;
            end else begin
                w.closed_count = '0;
            end
            if (item.open_switch &&
                (w.door_position == DOOR_OPENING || w.door_position == DOOR_BETWEEN)) begin
                w.open_count = (w.open_count == '1) ? w.open_count : w.open_count + 1'b1;
            end else begin
                w.open_count = '0;
            end
            if (item.push_button) begin
                w.press_count = (w.press_count == '1) ? w.press_count : w.press_count + 1'b1;
            end else if (w.press_count < PRESS_KEEP) begin
                w.press_count = '0;
            end
        end else begin
            w.sample_phase = w.sample_phase + 1'b1;
        end

        if (w.closed_count > cfg.switch_debounce) begin
            w.run_steps     = '0;
            w.closed_count  = '0;
            issued          = 1'b1;
            cmd             = DOOR_CLOSED;
            w.door_position = DOOR_CLOSED;
        end
        if (w.open_count > cfg.switch_debounce) begin
            w.run_steps     = '0;
            w.open_count    = '0;
            issued          = 1'b1;
            cmd             = DOOR_OPEN;
            w.door_position = DOOR_OPEN;
        end
        if (w.press_count > cfg.button_hold && !item.push_button) begin
            w.press_count = '0;
            press         = 1'b1;
            w.run_steps   = '0;
        end

        // automatic mode
        if (!w.mode_manual) begin
            if (!is_moving(w.door_position) && w.light_phase == LIGHT_LAST) begin
                fired         = 1'b1;
                w.light_state = item.light_class;
            end
            if ((w.door_position == DOOR_OPEN || w.door_position == DOOR_BETWEEN) &&
                w.light_state == LIGHT_NIGHT) begin
                issued          = 1'b1;
                cmd             = DOOR_CLOSING;
                w.door_position = DOOR_CLOSING;
            end
            if ((w.door_position == DOOR_CLOSED || w.door_position == DOOR_BETWEEN) &&
                w.light_state == LIGHT_DAY) begin
                issued          = 1'b1;
                cmd             = DOOR_OPENING;
                w.door_position = DOOR_OPENING;
            end
        end
        if (fired) begin
            w.light_phase = '0;
        end else if (w.light_phase < LIGHT_LAST) begin
            w.light_phase = w.light_phase + 1'b1;
        end

        // manual mode
        if (w.mode_manual && w.manual_elapsed > cfg.manual_timeout) begin
            w.mode_manual = 1'b0;
        end
        if (press) begin
            w.manual_elapsed = '0;
            w.mode_manual    = 1'b1;
            priority case (w.door_position)
                DOOR_OPENING, DOOR_CLOSING: begin
                    w.prior_motion  = w.door_position;
                    issued          = 1'b1;
                    cmd             = DOOR_BETWEEN;
                    w.door_position = DOOR_BETWEEN;
                end
                DOOR_CLOSED: w.door_position = DOOR_OPENING;
                DOOR_OPEN:   w.door_position = DOOR_CLOSING;
                DOOR_BETWEEN: begin
                    if (w.prior_motion == DOOR_CLOSING) begin
                        w.door_position = DOOR_OPENING;
                    end else if (w.prior_motion == DOOR_OPENING ||
                                 w.prior_motion == DOOR_BETWEEN) begin
                        w.door_position = DOOR_CLOSING;
                    end
                end
                default: w.door_position = w.door_position;
            endcase
        end

        // motor drive
        if (w.drive_phase == DRIVE_LAST && is_moving(w.door_position)) begin
            w.drive_phase = '0;
            issued        = 1'b1;
            cmd           = w.door_position;
            w.run_steps   = (w.run_steps == '1) ? w.run_steps : w.run_steps + 1'b1;
        end else if (w.drive_phase < DRIVE_LAST) begin
            w.drive_phase = w.drive_phase + 1'b1;
        end

        // protections
        if (!is_moving(w.door_position)) begin
            w.run_steps = '0;
        end

        if (w.sense_phase == SENSE_LAST) begin
            w.sense_phase = '0;
            if (w.run_steps > MIN_STEPS_FOR_CURRENT &&
                item.motor_milliamps > cfg.current_limit) begin
                w.overcurrent_count = (w.overcurrent_count == '1) ? w.overcurrent_count
                                                                  : w.overcurrent_count + 1'b1;
            end else begin
                w.overcurrent_count = '0;
            end
            if (item.bus_millivolts > cfg.voltage_high ||
                item.bus_millivolts < cfg.voltage_low) begin
                w.bad_voltage_count = (w.bad_voltage_count == '1) ? w.bad_voltage_count
                                                                  : w.bad_voltage_count + 1'b1;
            end else begin
                w.bad_voltage_count = '0;
            end
        end else begin
            w.sense_phase = w.sense_phase + 1'b1;
        end

        if (w.run_steps > cfg.run_step_limit) begin
            err             = ERR_RUN_LONG;
            issued          = 1'b1;
            cmd             = DOOR_BETWEEN;
            w.run_steps     = '0;
            w.door_position = DOOR_BETWEEN;
        end
        if (w.overcurrent_count > cfg.overcurrent_runs) begin
            w.overcurrent_count = '0;
            w.run_steps         = '0;
            issued              = 1'b1;
            if (w.door_position == DOOR_CLOSING) begin
                // current stall while closing means the door has reached the end
                w.closed_count  = '0;
                cmd             = DOOR_CLOSED;
                w.door_position = DOOR_CLOSED;
            end else begin
                err             = ERR_OVERCURRENT;
                cmd             = DOOR_BETWEEN;
                w.door_position = DOOR_BETWEEN;
            end
        end
        if (w.bad_voltage_count > BAD_VOLTAGE_RUNS) begin
            err                 = ERR_VOLTAGE;
            issued              = 1'b1;
            cmd                 = DOOR_BETWEEN;
            w.run_steps         = '0;
            w.door_position     = DOOR_BETWEEN;
            w.bad_voltage_count = '0;
        end

        st_next           = w;
        res.motor_issued  = issued;
        res.motor_command = cmd;
        res.door_state    = w.door_position;
        res.manual_mode   = w.mode_manual;
        res.error_event   = err;
    end

endmodule
